FILE: sv/c6502_pkg.sv
package c6502_pkg;

    localparam int unsigned DataW = 8;
    localparam int unsigned InTdataW = 16;
    localparam int unsigned OutTdataW = 64;

    // status flag bit positions
    localparam int unsigned FlC = 0;
    localparam int unsigned FlZ = 1;
    localparam int unsigned FlI = 2;
    localparam int unsigned FlD = 3;
    localparam int unsigned FlB = 4;
    localparam int unsigned FlU = 5;
    localparam int unsigned FlV = 6;
    localparam int unsigned FlN = 7;

    localparam logic [7:0] AneMagic = 8'hEE;
    localparam logic [7:0] SpReset = 8'hFD;
    localparam logic [7:0] FlagsReset = 8'h20;
    localparam logic [7:0] PushFlagMask = 8'h30;
    localparam logic [7:0] SignBit = 8'h80;
    localparam logic [7:0] OvfBit = 8'h40;

    // opcode groups (cc field)
    localparam logic [1:0] CcCtl = 2'd0;
    localparam logic [1:0] CcAlu = 2'd1;
    localparam logic [1:0] CcRmw = 2'd2;
    localparam logic [1:0] CcIll = 2'd3;

    // single opcodes
    localparam logic [7:0] OpPhp = 8'h08;
    localparam logic [7:0] OpPha = 8'h48;
    localparam logic [7:0] OpPlp = 8'h28;
    localparam logic [7:0] OpPla = 8'h68;
    localparam logic [7:0] OpDey = 8'h88;
    localparam logic [7:0] OpIny = 8'hC8;
    localparam logic [7:0] OpInx = 8'hE8;
    localparam logic [7:0] OpDex = 8'hCA;
    localparam logic [7:0] OpTay = 8'hA8;
    localparam logic [7:0] OpTya = 8'h98;
    localparam logic [7:0] OpClc = 8'h18;
    localparam logic [7:0] OpSec = 8'h38;
    localparam logic [7:0] OpCli = 8'h58;
    localparam logic [7:0] OpSei = 8'h78;
    localparam logic [7:0] OpClv = 8'hB8;
    localparam logic [7:0] OpCld = 8'hD8;
    localparam logic [7:0] OpSed = 8'hF8;
    localparam logic [7:0] OpBitZp = 8'h24;
    localparam logic [7:0] OpBitAbs = 8'h2C;
    localparam logic [7:0] OpStyZp = 8'h84;
    localparam logic [7:0] OpStyAbs = 8'h8C;
    localparam logic [7:0] OpStyZpx = 8'h94;
    localparam logic [7:0] OpLdyImm = 8'hA0;
    localparam logic [7:0] OpLdyZp = 8'hA4;
    localparam logic [7:0] OpLdyAbs = 8'hAC;
    localparam logic [7:0] OpLdyZpx = 8'hB4;
    localparam logic [7:0] OpLdyAbx = 8'hBC;
    localparam logic [7:0] OpCpyImm = 8'hC0;
    localparam logic [7:0] OpCpyZp = 8'hC4;
    localparam logic [7:0] OpCpyAbs = 8'hCC;
    localparam logic [7:0] OpCpxImm = 8'hE0;
    localparam logic [7:0] OpCpxZp = 8'hE4;
    localparam logic [7:0] OpCpxAbs = 8'hEC;
    localparam logic [7:0] OpNopImm = 8'h89;

    // alu kinds (aaa field)
    localparam logic [2:0] AluOra = 3'd0;
    localparam logic [2:0] AluAnd = 3'd1;
    localparam logic [2:0] AluEor = 3'd2;
    localparam logic [2:0] AluAdc = 3'd3;
    localparam logic [2:0] AluSta = 3'd4;
    localparam logic [2:0] AluLda = 3'd5;
    localparam logic [2:0] AluCmp = 3'd6;
    localparam logic [2:0] AluSbc = 3'd7;

    // shift kinds (aaa field)
    localparam logic [2:0] ShAsl = 3'd0;
    localparam logic [2:0] ShRol = 3'd1;
    localparam logic [2:0] ShLsr = 3'd2;
    localparam logic [2:0] ShRor = 3'd3;
    localparam logic [2:0] ShDec = 3'd6;
    localparam logic [2:0] ShInc = 3'd7;

    // N and Z from a result byte
    function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] r;
        r = f;
        r[FlZ] = (v == 8'h00);
        r[FlN] = v[7];
        return r;
    endfunction

    // binary add with carry, returns {acc, flags}
    function automatic logic [15:0] do_adc(input logic [7:0] a, input logic [7:0] f,
                                           input logic [7:0] v);
        logic [8:0] sum;
        logic [7:0] r;
        sum = {1'b0, a} + {1'b0, v} + {8'h00, f[FlC]};
        r = f;
        r[FlC] = sum[8];
        r[FlV] = ~(a[7] ^ v[7]) & (a[7] ^ sum[7]);
        r = set_nz(r, sum[7:0]);
        return {sum[7:0], r};
    endfunction

    // compare, returns flags
    function automatic logic [7:0] do_cmp(input logic [7:0] f, input logic [7:0] a,
                                          input logic [7:0] v);
        logic [7:0] r;
        r = f;
        r[FlC] = (a >= v);
        r = set_nz(r, a - v);
        return r;
    endfunction

    // accumulator alu op, returns {acc, flags}
    function automatic logic [15:0] do_alu(input logic [2:0] k, input logic [7:0] a,
                                           input logic [7:0] f, input logic [7:0] v);
        logic [15:0] r;
        r = {a, f};
        case (k)
            AluOra: r = {a | v, set_nz(f, a | v)};
            AluAnd: r = {a & v, set_nz(f, a & v)};
            AluEor: r = {a ^ v, set_nz(f, a ^ v)};
            AluAdc: r = do_adc(a, f, v);
            AluLda: r = {v, set_nz(f, v)};
            AluCmp: r = {a, do_cmp(f, a, v)};
            AluSbc: r = do_adc(a, f, ~v);
            default: r = {a, f};
        endcase
        return r;
    endfunction

    // shift, rotate, inc or dec, returns {result, flags}
    function automatic logic [15:0] do_rmw(input logic [2:0] k, input logic [7:0] f,
                                           input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] nf;
        nf = f;
        r = v;
        case (k)
            ShAsl: begin nf[FlC] = v[7]; r = {v[6:0], 1'b0}; end
            ShRol: begin nf[FlC] = v[7]; r = {v[6:0], f[FlC]}; end
            ShLsr: begin nf[FlC] = v[0]; r = {1'b0, v[7:1]}; end
            ShRor: begin nf[FlC] = v[0]; r = {f[FlC], v[7:1]}; end
            ShDec: r = v - 8'd1;
            ShInc: r = v + 8'd1;
            default: r = v;
        endcase
        return {r, set_nz(nf, r)};
    endfunction

endpackage

FILE: sv/cpu6502_execute_unit.sv
// Execute stage of a 6502-style core, decimal mode ignored.
// Input channel s_*: one item per instruction, tdata = {operand, op}.
// The operand is the immediate or memory byte, the pulled byte for PLA/PLP and
// the old memory byte for read-modify-write opcodes.
// Result channel m_*: one item per input item carrying the store byte and its
// valid flag, the stack slot of a push or pull, the branch condition and the
// A, X, Y, SP and status registers after the instruction.
// The result is registered and appears in the cycle after the item is accepted.
// Throughput: one item per cycle while each result is taken; the register and
// flag update of an instruction is short combinational logic feeding the
// architectural registers and the result register in the same cycle.
// A full result register that the receiver stalls still lets a new item in
// in the cycle that it is taken; otherwise s_tready drops until then.
// Reset: A, X, Y cleared, SP = 0xFD, status = 0x20, no result pending.
module cpu6502_execute_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[7:0], operand[15:8]
    input  logic [c6502_pkg::InTdataW-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // store_data[7:0], store_valid[8], stack_slot[16:9], branch_taken[17],
    // acc_out[25:18], x_out[33:26], y_out[41:34], sp_out[49:42],
    // flags_out[57:50], zero[63:58]
    output logic [c6502_pkg::OutTdataW-1:0]   m_tdata
);
    import c6502_pkg::*;

    logic [7:0] acc_reg, x_reg, y_reg, sp_reg, flags_reg;
    logic [7:0] acc_next, x_next, y_next, sp_next, flags_next;
    logic [7:0] sd_next, slot_next;
    logic       sv_next, br_next;
    logic       out_valid_reg;
    logic [OutTdataW-1:0] out_data_reg;
    logic       s_acc;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    // instruction decode and execute
    always_comb begin
        logic [7:0] op, v, a, x, y, sp, f, t;
        logic [1:0] cc;
        logic [2:0] aaa, bbb;
        logic [15:0] pr;
        logic [2:0] bpos;
        op = s_tdata[7:0];
        v = s_tdata[15:8];
        cc = op[1:0];
        aaa = op[7:5];
        bbb = op[4:2];
        a = acc_reg; x = x_reg; y = y_reg; sp = sp_reg; f = flags_reg;
        sd_next = 8'h00; slot_next = 8'h00; sv_next = 1'b0; br_next = 1'b0;
        t = 8'h00;
        pr = 16'h0000;
        bpos = 3'd0;
        if (cc == CcCtl && bbb == 3'd4) begin
            // branch condition
            case (aaa[2:1])
                2'd0: bpos = 3'(FlN);
                2'd1: bpos = 3'(FlV);
                2'd2: bpos = 3'(FlC);
                default: bpos = 3'(FlZ);
            endcase
            br_next = (f[bpos] == aaa[0]);
        end else if (cc == CcAlu) begin
            if (aaa == AluSta) begin
                if (op != OpNopImm) begin sd_next = a; sv_next = 1'b1; end
            end else begin
                pr = do_alu(aaa, a, f, v);
                a = pr[15:8]; f = pr[7:0];
            end
        end else if (cc == CcRmw) begin
            if (aaa < 3'd4 || aaa >= 3'd6) begin
                if (bbb[0]) begin
                    pr = do_rmw(aaa, f, v);
                    sd_next = pr[15:8]; f = pr[7:0]; sv_next = 1'b1;
                end else if (bbb == 3'd2 && aaa < 3'd4) begin
                    pr = do_rmw(aaa, f, a);
                    a = pr[15:8]; f = pr[7:0];
                end else if (op == OpDex) begin
                    x = x - 8'd1; f = set_nz(f, x);
                end
            end else if (aaa == 3'd4) begin
                if (bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) begin
                    sd_next = x; sv_next = 1'b1;
                end else if (bbb == 3'd2) begin
                    a = x; f = set_nz(f, a);
                end else if (bbb == 3'd6) begin
                    sp = x;
                end
            end else begin
                if (bbb == 3'd2) begin
                    x = a; f = set_nz(f, x);
                end else if (bbb == 3'd6) begin
                    x = sp; f = set_nz(f, x);
                end else if (bbb != 3'd4) begin
                    x = v; f = set_nz(f, x);
                end
            end
        end else if (cc == CcCtl) begin
            case (op)
                OpPhp: begin
                    slot_next = sp; sd_next = f | PushFlagMask; sv_next = 1'b1;
                    sp = sp - 8'd1;
                end
                OpPha: begin
                    slot_next = sp; sd_next = a; sv_next = 1'b1; sp = sp - 8'd1;
                end
                OpPlp: begin
                    sp = sp + 8'd1; slot_next = sp;
                    f = v; f[FlB] = 1'b0; f[FlU] = 1'b1;
                end
                OpPla: begin
                    sp = sp + 8'd1; slot_next = sp; a = v; f = set_nz(f, a);
                end
                OpDey: begin y = y - 8'd1; f = set_nz(f, y); end
                OpIny: begin y = y + 8'd1; f = set_nz(f, y); end
                OpInx: begin x = x + 8'd1; f = set_nz(f, x); end
                OpTay: begin y = a; f = set_nz(f, y); end
                OpTya: begin a = y; f = set_nz(f, a); end
                OpClc: f[FlC] = 1'b0;
                OpSec: f[FlC] = 1'b1;
                OpCli: f[FlI] = 1'b0;
                OpSei: f[FlI] = 1'b1;
                OpClv: f[FlV] = 1'b0;
                OpCld: f[FlD] = 1'b0;
                OpSed: f[FlD] = 1'b1;
                OpBitZp, OpBitAbs: begin
                    f[FlZ] = ((v & a) == 8'h00);
                    f[FlN] = v[7];
                    f[FlV] = v[6];
                end
                OpStyZp, OpStyAbs, OpStyZpx: begin sd_next = y; sv_next = 1'b1; end
                OpLdyImm, OpLdyZp, OpLdyAbs, OpLdyZpx, OpLdyAbx: begin
                    y = v; f = set_nz(f, y);
                end
                OpCpyImm, OpCpyZp, OpCpyAbs: f = do_cmp(f, y, v);
                OpCpxImm, OpCpxZp, OpCpxAbs: f = do_cmp(f, x, v);
                default: f = f;
            endcase
        end else if (bbb == 3'd2) begin
            // illegal immediate opcodes
            case (aaa)
                3'd0, 3'd1: begin
                    pr = do_alu(AluAnd, a, f, v);
                    a = pr[15:8]; f = pr[7:0]; f[FlC] = a[7];
                end
                3'd2: begin
                    pr = do_alu(AluAnd, a, f, v);
                    pr = do_rmw(ShLsr, pr[7:0], pr[15:8]);
                    a = pr[15:8]; f = pr[7:0];
                end
                3'd3: begin
                    pr = do_alu(AluAnd, a, f, v);
                    pr = do_rmw(ShRor, pr[7:0], pr[15:8]);
                    a = pr[15:8]; f = pr[7:0];
                    f[FlC] = a[6];
                    f[FlV] = a[6] ^ a[5];
                end
                3'd4: begin
                    a = (a | AneMagic) & x & v; f = set_nz(f, a);
                end
                3'd6: begin
                    t = a & x;
                    x = t - v;
                    f[FlC] = (t >= v);
                    f = set_nz(f, x);
                end
                3'd7: begin
                    pr = do_alu(AluSbc, a, f, v);
                    a = pr[15:8]; f = pr[7:0];
                end
                default: f = f;
            endcase
        end else if (aaa == 3'd4) begin
            if (bbb == 3'd0 || bbb == 3'd1 || bbb == 3'd3 || bbb == 3'd5) begin
                sd_next = a & x; sv_next = 1'b1;
            end
        end else if (aaa == 3'd5) begin
            if (bbb == 3'd6) begin
                t = v & sp; a = t; x = t; sp = t; f = set_nz(f, t);
            end else begin
                a = v; x = v; f = set_nz(f, v);
            end
        end else begin
            // illegal read-modify-write then alu
            pr = do_rmw(aaa, f, v);
            sd_next = pr[15:8]; f = pr[7:0]; sv_next = 1'b1;
            pr = do_alu(aaa, a, f, sd_next);
            a = pr[15:8]; f = pr[7:0];
        end
        acc_next = a; x_next = x; y_next = y; sp_next = sp; flags_next = f;
    end

    // architectural registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= 8'h00;
            x_reg <= 8'h00;
            y_reg <= 8'h00;
            sp_reg <= SpReset;
            flags_reg <= FlagsReset;
        end else if (s_acc) begin
            acc_reg <= acc_next;
            x_reg <= x_next;
            y_reg <= y_next;
            sp_reg <= sp_next;
            flags_reg <= flags_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_data_reg <= {6'b0, flags_next, sp_next, y_next, x_next, acc_next,
                             br_next, slot_next, sv_next, sd_next};
        end
    end

    // unused status bit never clears
    assert property (@(posedge aclk) disable iff (!aresetn) flags_reg[FlU])
        else $error("unused status bit cleared");

    // architectural state only moves on an accepted item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_acc |=> $stable(sp_reg) && $stable(acc_reg) && $stable(flags_reg))
        else $error("state changed without an item");

    // branch opcodes never store
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg[17] |-> !out_data_reg[8])
        else $error("branch with store");

    // result carries the current register file
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg[25:18] == acc_reg && out_data_reg[49:42] == sp_reg)
        else $error("result out of step with registers");

endmodule
